FILE: design/dtf_pkg.sv
// Shared types and constants for the decimal text formatter.
`timescale 1ns / 1ps
package dtf_pkg;

	localparam int NUM_DIGITS = 10;
	localparam int DIG_W      = 4;
	localparam int VAL_W      = 32;
	localparam int CHAR_W     = 7;

	// floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VAL_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int               RECIP_SHIFT = 35;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic emit_last;
	} stat_t;

endpackage

FILE: design/dtf_ctrl.sv
// Controller state machine: load, digit conversion, character emission.
`timescale 1ns / 1ps
module dtf_ctrl
	import dtf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (stat.conv_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CONV: cmd.conv = 1'b1;
			ST_EMIT: cmd.emit = 1'b1;
			default: busy = 1'b0;
		endcase
	end

endmodule

FILE: design/dtf_datapath.sv
// Datapath: magnitude register, divide-by-ten step, digit store, character output.
`timescale 1ns / 1ps
module dtf_datapath
	import dtf_pkg::*;
#(
	parameter int MAX_CHARS = 15,
	parameter int CW        = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [VAL_W-1:0]  value,
	input  logic              is_signed,
	input  logic [3:0]        width,
	output logic [CHAR_W-1:0] character,
	output logic              last,
	output logic              strobe
);

	localparam logic [CW-1:0] MAX_W = CW'(MAX_CHARS);

	logic [VAL_W-1:0]  mag_q;
	logic              neg_q;
	logic [CW-1:0]     wsat_q;
	logic [DIG_W-1:0]  nd_q;
	logic [DIG_W-1:0]  digits_q [NUM_DIGITS];
	logic [CW-1:0]     k_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              strobe_q;

	logic              in_neg;
	logic [CW-1:0]     w_ext;
	logic [2*VAL_W-1:0] prod;
	logic [VAL_W-1:0]  quo;
	logic [VAL_W-1:0]  rem_full;
	logic [CW-1:0]     textlen;
	logic [CW-1:0]     total;
	logic [CW-1:0]     pad;
	logic [CW-1:0]     didx;
	logic [CHAR_W-1:0] char_d;
	logic              is_last;

	assign in_neg = is_signed & value[VAL_W-1];
	assign w_ext  = CW'(width);

	// reciprocal multiply gives the quotient, the remainder is the next digit
	assign prod     = mag_q * RECIP_10;
	assign quo      = VAL_W'(prod[2*VAL_W-1:RECIP_SHIFT]);
	assign rem_full = mag_q - (quo << 3) - (quo << 1);

	assign textlen = CW'(nd_q) + CW'(neg_q);
	assign total   = (textlen > wsat_q) ? textlen : wsat_q;
	assign pad     = total - textlen;
	assign didx    = total - CW'(1) - k_q;
	assign is_last = (k_q == total - CW'(1));

	always_comb begin
		if (k_q < pad) begin
			char_d = CH_SPACE;
		end else if (neg_q && (k_q == pad)) begin
			char_d = CH_MINUS;
		end else begin
			char_d = CH_ZERO + CHAR_W'(digits_q[didx[DIG_W-1:0]]);
		end
	end

	assign stat.conv_done = (mag_q < VAL_W'(10));
	assign stat.emit_last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q     <= '0;
			k_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				nd_q <= '0;
				k_q  <= '0;
			end else begin
				if (cmd.conv) nd_q <= nd_q + DIG_W'(1);
				if (cmd.emit) k_q <= k_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q  <= in_neg ? (~value + VAL_W'(1)) : value;
			neg_q  <= in_neg;
			wsat_q <= (w_ext > MAX_W) ? MAX_W : w_ext;
		end else if (cmd.conv) begin
			mag_q          <= quo;
			digits_q[nd_q] <= rem_full[DIG_W-1:0];
		end
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= is_last;
		end
	end

	assign character = char_q;
	assign last      = last_q;
	assign strobe    = strobe_q;

endmodule

FILE: design/decimal_text_formatter.sv
// Conversion produces one digit per cycle through the reciprocal multiplier, D = digit
// count (1..10), then one character leaves per cycle on the single output port, N =
// characters out (1..MAX_CHARS). A new item is taken only in idle, after the last
// character; start is ignored while busy. The receiver cannot stall the output.
// Reset (arst_n low) returns the controller to idle and clears the strobe at once.
`timescale 1ns / 1ps
module decimal_text_formatter
	import dtf_pkg::*;
#(
	parameter int MAX_CHARS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [VAL_W-1:0]  value,
	input  logic              is_signed,
	input  logic [3:0]        width,
	output logic [CHAR_W-1:0] character,
	output logic              last,
	output logic              strobe
);

	localparam int CW = $clog2(MAX_CHARS + 1);

	cmd_t  cmd;
	stat_t stat;

	dtf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dtf_datapath #(
		.MAX_CHARS (MAX_CHARS),
		.CW        (CW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.value     (value),
		.is_signed (is_signed),
		.width     (width),
		.character (character),
		.last      (last),
		.strobe    (strobe)
	);

endmodule
